// ----- src/nrp_pkg.sv -----
// Shared types and constants of the notice/progress-poll sequencer.
package nrp_pkg;

  // input item kinds
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_REPLY = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_SEND   = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  // finish outcomes
  localparam logic [1:0] OUTC_SUCCESS   = 2'd0;
  localparam logic [1:0] OUTC_EXHAUSTED = 2'd1;
  localparam logic [1:0] OUTC_PEER_ERR  = 2'd2;

  // command codes
  localparam logic [15:0] CODE_NOTICE = 16'h01BB;
  localparam logic [15:0] CODE_QUERY  = 16'h01CC;

  // status low byte classification masks
  localparam logic [7:0] STAT_ERR_BIT  = 8'h80;
  localparam logic [7:0] STAT_CODE_MSK = 8'h03;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 4;
  localparam logic [CfgIdxW-1:0] REG_NOTICE_TO   = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_QUERY_TO    = 4'd1;
  localparam logic [CfgIdxW-1:0] REG_QUERY_INTV  = 4'd2;
  localparam logic [CfgIdxW-1:0] REG_MAX_ATTEMPT = 4'd3;

  // register reset values
  localparam logic [15:0] RST_NOTICE_TO   = 16'd5000;
  localparam logic [15:0] RST_QUERY_TO    = 16'd5000;
  localparam logic [15:0] RST_QUERY_INTV  = 16'd3000;
  localparam logic [7:0]  RST_MAX_ATTEMPT = 8'd5;

  // result queue depth default
  localparam int unsigned OUTQ_DEPTH = 4;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_NOTICE = 4'b0010,
    PH_QWAIT  = 4'b0100,
    PH_QGAP   = 4'b1000
  } nrp_phase_e;

  typedef struct packed {
    logic [1:0]  op;
    logic        reply_valid;
    logic [15:0] reply_code;
    logic [15:0] reply_status;
  } nrp_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] cmd_code;
    logic [7:0]  seq_num;
    logic [15:0] report_status;
    logic [1:0]  outcome;
    logic        last;
  } nrp_res_t;

  // results of one processed item, up to two
  typedef struct packed {
    logic [1:0] num;
    nrp_res_t   r0;
    nrp_res_t   r1;
  } nrp_push_t;

endpackage

// ----- src/nrp_core.sv -----
// Configuration registers, sequencer state and the per-item step logic.
module nrp_core import nrp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               fire_i,
  input  nrp_item_t          item_i,
  output nrp_push_t          push_o
);

  logic [15:0] notice_to_q, query_to_q, query_intv_q;
  logic [7:0]  max_att_q;

  nrp_phase_e  phase_q, phase_d;
  logic [7:0]  att_q, att_d;
  logic [15:0] el_q, el_d;

  logic [7:0]  lo;
  logic        is_err, is_done, reply_ok;
  logic [15:0] el_tick;
  logic        do_notice, do_query, do_fail, do_over;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      notice_to_q  <= RST_NOTICE_TO;
      query_to_q   <= RST_QUERY_TO;
      query_intv_q <= RST_QUERY_INTV;
      max_att_q    <= RST_MAX_ATTEMPT;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_NOTICE_TO:   notice_to_q  <= cfg_data_i;
        REG_QUERY_TO:    query_to_q   <= cfg_data_i;
        REG_QUERY_INTV:  query_intv_q <= cfg_data_i;
        REG_MAX_ATTEMPT: max_att_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      att_q   <= '0;
      el_q    <= '0;
    end else begin
      phase_q <= phase_d;
      att_q   <= att_d;
      el_q    <= el_d;
    end
  end

  assign lo       = item_i.reply_status[7:0];
  assign is_err   = ((lo & STAT_ERR_BIT) != 8'h00) || ((lo & STAT_CODE_MSK) == 8'h03);
  assign is_done  = (lo & STAT_CODE_MSK) == 8'h01;
  assign el_tick  = (phase_q != PH_IDLE && el_q != 16'hFFFF) ? el_q + 16'd1 : el_q;

  always_comb begin
    phase_d   = phase_q;
    att_d     = att_q;
    el_d      = el_q;
    push_o    = '0;
    do_notice = 1'b0;
    do_query  = 1'b0;
    do_fail   = 1'b0;
    do_over   = 1'b0;
    reply_ok  = 1'b0;

    if (fire_i) begin
      case (item_i.op)
        OP_START: begin
          if (phase_q == PH_IDLE) begin
            att_d     = 8'd1;
            do_notice = 1'b1;
          end
        end
        OP_TICK: begin
          el_d = el_tick;
          case (phase_q)
            PH_NOTICE: do_fail  = el_tick >= notice_to_q;
            PH_QWAIT:  do_over  = el_tick >= query_to_q;
            PH_QGAP:   do_query = el_tick >= query_intv_q;
            default: ;
          endcase
        end
        OP_REPLY: begin
          case (phase_q)
            PH_NOTICE: begin
              reply_ok = item_i.reply_valid && item_i.reply_code == CODE_NOTICE && !is_err;
              do_fail  = !reply_ok;
              do_query = reply_ok;
            end
            PH_QWAIT: begin
              if (item_i.reply_valid && item_i.reply_code == CODE_QUERY &&
                  (is_err || is_done)) begin
                phase_d                 = PH_IDLE;
                push_o.num              = 2'd2;
                push_o.r0.kind          = KIND_REPORT;
                push_o.r0.cmd_code      = CODE_QUERY;
                push_o.r0.report_status = item_i.reply_status;
                push_o.r1.kind          = KIND_FINISH;
                push_o.r1.outcome       = is_err ? OUTC_PEER_ERR : OUTC_SUCCESS;
              end else begin
                do_over = 1'b1;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase

      // wait over: send at once if the interval already passed
      if (do_over) begin
        if (el_d >= query_intv_q) begin
          do_query = 1'b1;
        end else begin
          phase_d = PH_QGAP;
        end
      end

      if (do_fail) begin
        if (att_q >= max_att_q) begin
          phase_d           = PH_IDLE;
          push_o.num        = 2'd1;
          push_o.r0.kind    = KIND_FINISH;
          push_o.r0.outcome = OUTC_EXHAUSTED;
        end else begin
          att_d     = att_q + 8'd1;
          do_notice = 1'b1;
        end
      end

      if (do_notice) begin
        el_d               = '0;
        phase_d            = PH_NOTICE;
        push_o.num         = 2'd2;
        push_o.r0.kind     = KIND_REPORT;
        push_o.r0.cmd_code = CODE_NOTICE;
        push_o.r1.kind     = KIND_SEND;
        push_o.r1.cmd_code = CODE_NOTICE;
        push_o.r1.seq_num  = att_d;
      end

      if (do_query) begin
        el_d               = '0;
        phase_d            = PH_QWAIT;
        push_o.num         = 2'd1;
        push_o.r0.kind     = KIND_SEND;
        push_o.r0.cmd_code = CODE_QUERY;
        push_o.r0.seq_num  = 8'd1;
      end

      push_o.r0.last = push_o.num == 2'd1;
      push_o.r1.last = push_o.num == 2'd2;
    end
  end

endmodule

// ----- src/nrp_outq.sv -----
// Small result queue: takes up to two results a cycle, hands out one.
module nrp_outq import nrp_pkg::*; #(
  parameter int unsigned Depth = OUTQ_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  nrp_push_t push_i,
  output logic      room_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output nrp_res_t  out_res_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  nrp_res_t            mem_q [Depth];
  logic [PtrW-1:0]     head_q, tail_q, tail1;
  logic [CntW-1:0]     count_q;
  logic                pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(Depth - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign tail1       = ptr_inc(tail_q);
  assign out_valid_o = count_q != '0;
  assign pop         = out_valid_o && out_ready_i;
  assign out_res_o   = mem_q[head_q];
  // room for a full pair, so a processed item never waits on a partial write
  assign room_o      = count_q <= CntW'(Depth - 2);

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[tail_q] <= push_i.r0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[tail1] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      if (pop) begin
        head_q <= ptr_inc(head_q);
      end
      case (push_i.num)
        2'd1:    tail_q <= tail1;
        2'd2:    tail_q <= ptr_inc(tail1);
        default: ;
      endcase
      count_q <= count_q + CntW'(push_i.num) - CntW'(pop);
    end
  end

endmodule

// ----- src/notice_retry_then_progress_poll_unit.sv -----
// Top level of the notice-retry then progress-poll command sequencer.
//
// One input item (start, 1 ms tick, or reply) is taken per cycle while
// in_ready_o is high. An accepted item lands in an input register; once
// the result queue has room for a pair the step logic updates phase,
// attempt count and elapsed-ms state and writes the zero, one or two
// results it causes into a Depth-entry result queue (default four).
// Results leave one per cycle while out_ready_i is high, so the sustained
// rate is one item per cycle for items with at most one result; while
// items keep producing two (notice acknowledgement plus send, or report
// plus finish) the queue fills and the input stalls. An item passes the
// input register and its results the result queue, both registered.
// The input register stalls only when the result queue lacks room for a
// pair. Configuration writes are always taken (cfg_ready_o tied high) and
// must only be issued while the unit is idle. Register indexes: 0 notice
// timeout, 1 query timeout, 2 query interval (all ms ticks), 3 max
// attempts; other indexes are ignored.
module notice_retry_then_progress_poll_unit import nrp_pkg::*; #(
  parameter int unsigned OutqDepth = OUTQ_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  // input items
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic               reply_valid_i,
  input  logic [15:0]        reply_code_i,
  input  logic [15:0]        reply_status_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic [15:0]        cmd_code_o,
  output logic [7:0]         seq_num_o,
  output logic [15:0]        report_status_o,
  output logic [1:0]         outcome_o,
  output logic               last_o
);

  nrp_item_t item_q;
  logic      item_vld_q;
  logic      room, fire, in_xfer;
  nrp_push_t push;
  nrp_res_t  head;

  assign cfg_ready_o = 1'b1;

  // process the held item once the queue can absorb its results
  assign fire       = item_vld_q && room;
  assign in_ready_o = !item_vld_q || fire;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_xfer) begin
      item_vld_q <= 1'b1;
    end else if (fire) begin
      item_vld_q <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.op           <= op_i;
      item_q.reply_valid  <= reply_valid_i;
      item_q.reply_code   <= reply_code_i;
      item_q.reply_status <= reply_status_i;
    end
  end

  nrp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fire_i      (fire),
    .item_i      (item_q),
    .push_o      (push)
  );

  nrp_outq #(
    .Depth (OutqDepth)
  ) u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (head)
  );

  assign kind_o          = head.kind;
  assign cmd_code_o      = head.cmd_code;
  assign seq_num_o       = head.seq_num;
  assign report_status_o = head.report_status;
  assign outcome_o       = head.outcome;
  assign last_o          = head.last;

endmodule

// ----- src/nrp_checker.sv -----
// Port-level checks of the sequencer's result stream, bound to the top level.
module nrp_checker import nrp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  kind_o,
  input logic [15:0] cmd_code_o,
  input logic [7:0]  seq_num_o,
  input logic [15:0] report_status_o,
  input logic [1:0]  outcome_o,
  input logic        last_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) &&
      $stable(cmd_code_o) && $stable(seq_num_o) && $stable(last_o))
    else $error("result changed while stalled");

  // a finish always closes its item's results
  a_finish_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_FINISH |-> last_o && cmd_code_o == 16'h0000)
    else $error("finish not last");

  // notice acknowledgement is always followed by its send
  a_ack_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && kind_o == KIND_REPORT && cmd_code_o == CODE_NOTICE
    |-> !last_o && report_status_o == 16'h0000
    ##1 out_valid_o && kind_o == KIND_SEND && cmd_code_o == CODE_NOTICE)
    else $error("notice ack without send");

  // a send carries no status or outcome and is last of its item
  a_send_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_SEND
    |-> last_o && report_status_o == 16'h0000 && outcome_o == OUTC_SUCCESS)
    else $error("malformed send");

endmodule

bind notice_retry_then_progress_poll_unit nrp_checker u_nrp_checker (.*);
